[rtl/core/bdilc_pkg.sv]
// Shared types and constants for the base-delta-immediate line size classifier.
// No dependencies; every other file of the block imports this package.
package bdilc_pkg;

    localparam int WORD_W = 64;

    // Encoding codes reported with each line result.
    typedef enum logic [3:0] {
        ENC_ZERO = 4'd0,
        ENC_REP  = 4'd1,
        ENC_B8D1 = 4'd2,
        ENC_B4D1 = 4'd3,
        ENC_B8D2 = 4'd4,
        ENC_B2D1 = 4'd5,
        ENC_B4D2 = 4'd6,
        ENC_B8D4 = 4'd7,
        ENC_NONE = 4'd8
    } t_encoding;

    // Fail flags of the six base-delta modes, in priority order.
    typedef struct packed {
        logic b8d1;
        logic b4d1;
        logic b8d2;
        logic b2d1;
        logic b4d2;
        logic b8d4;
    } t_mode_flags;

    // Line-level summary handed from the datapath to the encoder.
    typedef struct packed {
        logic        any_nonzero;
        logic        repeat_failed;
        t_mode_flags mode_failed;
    } t_line_status;

    localparam int SIZE_W = 7;
    localparam int SIZE_MAX = 127;

endpackage

[rtl/core/bdilc_mode_lane.sv]
// One base-delta mode: base register, base valid and fail flags, and the
// segment checks of one word. Depends on bdilc_pkg.
module bdilc_mode_lane #(
    parameter int SEG_W   = 16,
    parameter int NSEG    = 4,
    parameter int DELTA_W = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_advance,
    input  logic                     i_clear,
    input  logic [bdilc_pkg::WORD_W-1:0] i_word,
    output logic                     o_failed_next
);
    import bdilc_pkg::*;

    logic [SEG_W-1:0] r_base;
    logic             r_base_valid;
    logic             r_failed;
    logic [SEG_W-1:0] n_base;
    logic             n_base_valid;
    logic             n_failed;

    // Segments are checked from the most significant one down; a segment
    // above the immediate limit may set the base that later segments use.
    always_comb begin
        logic [SEG_W-1:0] seg;
        logic [SEG_W-1:0] diff;
        n_base       = r_base;
        n_base_valid = r_base_valid;
        n_failed     = r_failed;
        seg          = '0;
        diff         = '0;
        for (int k = 0; k < NSEG; k++) begin
            seg = i_word[SEG_W*(NSEG-1-k) +: SEG_W];
            if (!n_failed && (|seg[SEG_W-1:DELTA_W])) begin
                if (!n_base_valid) begin
                    n_base_valid = 1'b1;
                    n_base       = seg;
                end
                diff = (seg >= n_base) ? (seg - n_base) : (n_base - seg);
                if (|diff[SEG_W-1:DELTA_W]) begin
                    n_failed = 1'b1;
                end
            end
        end
    end

    assign o_failed_next = n_failed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_valid <= 1'b0;
            r_failed     <= 1'b0;
        end else if (i_advance) begin
            r_base_valid <= i_clear ? 1'b0 : n_base_valid;
            r_failed     <= i_clear ? 1'b0 : n_failed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_base <= n_base;
        end
    end

endmodule

[rtl/core/bdilc_encoder.sv]
// Picks the first encoding that succeeds for a finished line and its size.
// Depends on bdilc_pkg.
module bdilc_encoder #(
    parameter int WORDS      = 8,
    parameter int LINE_BYTES = 64
) (
    input  bdilc_pkg::t_line_status      i_status,
    output logic [bdilc_pkg::SIZE_W-1:0] o_size,
    output bdilc_pkg::t_encoding         o_encoding
);
    import bdilc_pkg::*;

    localparam int SZ_ZERO_I = 1;
    localparam int SZ_REP_I  = 8;
    localparam int SZ_B8D1_I = 8 + WORDS;
    localparam int SZ_B4D1_I = 4 + 2 * WORDS;
    localparam int SZ_B8D2_I = 8 + 2 * WORDS;
    localparam int SZ_B2D1_I = 2 + 4 * WORDS;
    localparam int SZ_B4D2_I = 4 + 4 * WORDS;
    localparam int SZ_B8D4_I = 8 + 4 * WORDS;
    localparam int SZ_NONE_I = LINE_BYTES;

    // Sizes above the field range saturate.
    localparam logic [SIZE_W-1:0] SZ_ZERO = SIZE_W'(SZ_ZERO_I);
    localparam logic [SIZE_W-1:0] SZ_REP  = SIZE_W'(SZ_REP_I);
    localparam logic [SIZE_W-1:0] SZ_B8D1 =
        SIZE_W'((SZ_B8D1_I > SIZE_MAX) ? SIZE_MAX : SZ_B8D1_I);
    localparam logic [SIZE_W-1:0] SZ_B4D1 =
        SIZE_W'((SZ_B4D1_I > SIZE_MAX) ? SIZE_MAX : SZ_B4D1_I);
    localparam logic [SIZE_W-1:0] SZ_B8D2 =
        SIZE_W'((SZ_B8D2_I > SIZE_MAX) ? SIZE_MAX : SZ_B8D2_I);
    localparam logic [SIZE_W-1:0] SZ_B2D1 =
        SIZE_W'((SZ_B2D1_I > SIZE_MAX) ? SIZE_MAX : SZ_B2D1_I);
    localparam logic [SIZE_W-1:0] SZ_B4D2 =
        SIZE_W'((SZ_B4D2_I > SIZE_MAX) ? SIZE_MAX : SZ_B4D2_I);
    localparam logic [SIZE_W-1:0] SZ_B8D4 =
        SIZE_W'((SZ_B8D4_I > SIZE_MAX) ? SIZE_MAX : SZ_B8D4_I);
    localparam logic [SIZE_W-1:0] SZ_NONE =
        SIZE_W'((SZ_NONE_I > SIZE_MAX) ? SIZE_MAX : SZ_NONE_I);

    always_comb begin
        priority if (!i_status.any_nonzero) begin
            o_size = SZ_ZERO;  o_encoding = ENC_ZERO;
        end else if (!i_status.repeat_failed) begin
            o_size = SZ_REP;   o_encoding = ENC_REP;
        end else if (!i_status.mode_failed.b8d1) begin
            o_size = SZ_B8D1;  o_encoding = ENC_B8D1;
        end else if (!i_status.mode_failed.b4d1) begin
            o_size = SZ_B4D1;  o_encoding = ENC_B4D1;
        end else if (!i_status.mode_failed.b8d2) begin
            o_size = SZ_B8D2;  o_encoding = ENC_B8D2;
        end else if (!i_status.mode_failed.b2d1) begin
            o_size = SZ_B2D1;  o_encoding = ENC_B2D1;
        end else if (!i_status.mode_failed.b4d2) begin
            o_size = SZ_B4D2;  o_encoding = ENC_B4D2;
        end else if (!i_status.mode_failed.b8d4) begin
            o_size = SZ_B8D4;  o_encoding = ENC_B8D4;
        end else begin
            o_size = SZ_NONE;  o_encoding = ENC_NONE;
        end
    end

endmodule

[rtl/core/bdi_line_size_classifier.sv]
// Top level of the base-delta-immediate line size classifier.
// Depends on bdilc_pkg, bdilc_mode_lane and bdilc_encoder.
//
// Usage: a cache line arrives on the slave stream as LINE_BYTES/8 words of
// 64 bits, one word per item, first line byte in tdata[63:56]. There is no
// framing input: the block counts words and the last word of each line
// closes it. For every line one result item leaves on the master stream
// carrying the compressed size and the encoding that was chosen.
// Throughput is one word per cycle unless a stall holds the input register. Each
// word goes through the input register, where the six mode lanes and the zero and
// repeat trackers update; when the last word of a line leaves it, the result is
// loaded into the output register, which drives o_m_axis_tvalid, and waits there
// until the receiver takes it.
// The output register lets the next line's words keep flowing while a result
// waits; only a last word that finds the previous result still untaken waits
// in the input register, and then o_s_axis_tready drops until the receiver
// takes the result.
// Reset (synchronous, active low) empties both registers and starts a new
// line; no clearing pass is needed.
module bdi_line_size_classifier #(
    parameter int LINE_BYTES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,   // [63:0] line_word
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata    // [6:0] compressed_size, [10:7] encoding
);
    import bdilc_pkg::*;

    localparam int WORDS = ((LINE_BYTES / 8) < 1) ? 1 : (LINE_BYTES / 8);
    localparam int IDX_W = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WORDS - 1);

    logic                r_in_valid;
    logic [WORD_W-1:0]   r_in_word;
    logic [IDX_W-1:0]    r_word_index;
    logic                r_any_nonzero;
    logic                r_repeat_failed;
    logic [WORD_W-1:0]   r_first_word;
    logic                r_out_valid;
    logic [SIZE_W-1:0]   r_out_size;
    t_encoding           r_out_enc;

    logic                is_last;
    logic                advance;
    logic                accept;
    logic                n_any_nonzero;
    logic                n_repeat_failed;
    t_line_status        line_status;
    logic [SIZE_W-1:0]   enc_size;
    t_encoding           enc_code;

    assign is_last = (r_word_index == LAST_IDX);
    // A last word can leave the input register only if the output slot is empty or frees.
    assign advance = r_in_valid && (!is_last || !r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;
    assign accept = i_s_axis_tvalid && o_s_axis_tready;

    assign n_any_nonzero   = r_any_nonzero || (r_in_word != '0);
    assign n_repeat_failed = r_repeat_failed ||
                             ((r_word_index != '0) && (r_in_word != r_first_word));

    assign line_status.any_nonzero   = n_any_nonzero;
    assign line_status.repeat_failed = n_repeat_failed;

    bdilc_mode_lane #(.SEG_W(64), .NSEG(1), .DELTA_W(8)) u_lane_b8d1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_advance(advance), .i_clear(is_last),
        .i_word(r_in_word), .o_failed_next(line_status.mode_failed.b8d1)
    );
    bdilc_mode_lane #(.SEG_W(32), .NSEG(2), .DELTA_W(8)) u_lane_b4d1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_advance(advance), .i_clear(is_last),
        .i_word(r_in_word), .o_failed_next(line_status.mode_failed.b4d1)
    );
    bdilc_mode_lane #(.SEG_W(64), .NSEG(1), .DELTA_W(16)) u_lane_b8d2 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_advance(advance), .i_clear(is_last),
        .i_word(r_in_word), .o_failed_next(line_status.mode_failed.b8d2)
    );
    bdilc_mode_lane #(.SEG_W(16), .NSEG(4), .DELTA_W(8)) u_lane_b2d1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_advance(advance), .i_clear(is_last),
        .i_word(r_in_word), .o_failed_next(line_status.mode_failed.b2d1)
    );
    bdilc_mode_lane #(.SEG_W(32), .NSEG(2), .DELTA_W(16)) u_lane_b4d2 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_advance(advance), .i_clear(is_last),
        .i_word(r_in_word), .o_failed_next(line_status.mode_failed.b4d2)
    );
    bdilc_mode_lane #(.SEG_W(64), .NSEG(1), .DELTA_W(32)) u_lane_b8d4 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_advance(advance), .i_clear(is_last),
        .i_word(r_in_word), .o_failed_next(line_status.mode_failed.b8d4)
    );

    bdilc_encoder #(.WORDS(WORDS), .LINE_BYTES(LINE_BYTES)) u_encoder (
        .i_status(line_status),
        .o_size(enc_size),
        .o_encoding(enc_code)
    );

    // Input register and per-line tracking state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid      <= 1'b0;
            r_word_index    <= '0;
            r_any_nonzero   <= 1'b0;
            r_repeat_failed <= 1'b0;
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_word_index    <= is_last ? '0 : r_word_index + 1'b1;
                r_any_nonzero   <= is_last ? 1'b0 : n_any_nonzero;
                r_repeat_failed <= is_last ? 1'b0 : n_repeat_failed;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_word <= i_s_axis_tdata;
        end
        if (advance && (r_word_index == '0)) begin
            r_first_word <= r_in_word;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && is_last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && is_last) begin
            r_out_size <= enc_size;
            r_out_enc  <= enc_code;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'b0, 4'(r_out_enc), r_out_size};

endmodule

[verif/tb_bdi_line_size_classifier.sv]
// Self-checking testbench for bdi_line_size_classifier: streams cache lines word by word,
// predicts each line's encoding and compressed size, and checks the master stream.
// Depends on bdilc_pkg and the RTL of the block.
module tb_bdi_line_size_classifier;
    timeunit 1ns;
    timeprecision 1ps;

    import bdilc_pkg::*;

    localparam int LINE_BYTES = 64;
    localparam int WORDS = (LINE_BYTES / 8) < 1 ? 1 : LINE_BYTES / 8;
    localparam int LINES_PER_PHASE = 1750 / 8 / 3;
    localparam int QUIET_LIMIT = 4000;
    localparam int LONG_HOLD = 400;

    // Base-delta modes in priority order: segment bytes, delta bytes and the code.
    localparam int MODE_BASE_BYTES[6] = '{8, 4, 8, 2, 4, 8};
    localparam int MODE_DELTA_BYTES[6] = '{1, 1, 2, 1, 2, 4};
    localparam t_encoding MODE_ENC[6] = '{ENC_B8D1, ENC_B4D1, ENC_B8D2,
                                          ENC_B2D1, ENC_B4D2, ENC_B8D4};

    typedef struct {
        logic [6:0] size;
        t_encoding  enc;
    } line_class_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [63:0] i_s_axis_tdata = '0;     // [63:0] line_word
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [15:0] o_m_axis_tdata;          // [6:0] compressed_size, [10:7] encoding

    logic [63:0] line_words[$];
    line_class_t expected_classes[$];

    int  err_count = 0;
    int  snd_idle_pct = 14;
    int  rcv_idle_pct = 45;
    int  stall_req = 0;
    int  stall_seen = 0;
    int  hold_left = 0;
    bit  in_taken = 1'b0;

    // Running state of the line being classified.
    int          word_count;
    bit          any_nonzero;
    logic [63:0] first_word;
    bit          repeat_failed;
    bit          base_valid[6];
    bit          mode_failed[6];
    logic [63:0] mode_base[6];

    bdi_line_size_classifier #(
        .LINE_BYTES(LINE_BYTES)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] width_mask(int bytes);
        return (bytes >= 8) ? '1 : ((64'd1 << (8 * bytes)) - 64'd1);
    endfunction

    function void clear_line();
        word_count = 0;
        any_nonzero = 1'b0;
        first_word = '0;
        repeat_failed = 1'b0;
        for (int m = 0; m < 6; m++) begin
            base_valid[m] = 1'b0;
            mode_failed[m] = 1'b0;
            mode_base[m] = '0;
        end
    endfunction

    task automatic report_error(input string msg);
        err_count++;
        if (err_count <= 40) begin
            $display("%0t ns: mismatch: %s", $realtime, msg);
        end
    endtask

    // Queues one line of WORDS words. Kinds: 0 zero, 1 repeated word, 2..7 a line aimed
    // at one base-delta mode, 8 random words, 9 repeated word with one bit flipped once.
    // With edge_vals the aimed lines use only deltas and immediates at their limits.
    task automatic push_line(input int kind, input bit edge_vals);
        int          m;
        int          sb;
        int          db;
        int          r;
        int          pos;
        logic [63:0] wmask;
        logic [63:0] lim;
        logic [63:0] base;
        logic [63:0] w;
        logic [63:0] v;
        logic [63:0] d;
        if (kind == 0) begin
            repeat (WORDS) line_words.push_back('0);
        end else if (kind == 1) begin
            w = rand64();
            repeat (WORDS) line_words.push_back(w);
        end else if (kind == 8) begin
            repeat (WORDS) line_words.push_back(rand64());
        end else if (kind == 9) begin
            w = rand64();
            pos = $urandom_range(0, WORDS - 1);
            for (int i = 0; i < WORDS; i++) begin
                line_words.push_back(i == pos ? w ^ (64'd1 << $urandom_range(0, 63)) : w);
            end
        end else begin
            m = kind - 2;
            sb = MODE_BASE_BYTES[m];
            db = MODE_DELTA_BYTES[m];
            wmask = width_mask(sb);
            lim = width_mask(db);
            // Setting one bit above the delta width keeps the base out of immediate range.
            base = (rand64() & wmask) | (64'd1 << (8 * sb - 1 - $urandom_range(0, 8 * (sb - db) - 1)));
            for (int i = 0; i < WORDS; i++) begin
                w = '0;
                for (int j = 0; j < 8 / sb; j++) begin
                    r = edge_vals ? $urandom_range(0, 16) : $urandom_range(0, 19);
                    if (r < 4) begin
                        v = edge_vals ? (r[0] ? lim : '0) : (rand64() & lim);
                    end else if (r < 17) begin
                        d = edge_vals ? lim : (rand64() & lim);
                        v = $urandom_range(0, 1) ? base + d : base - d;
                    end else if (r < 18) begin
                        v = $urandom_range(0, 1) ? base + lim + 64'd1 : base - lim - 64'd1;
                    end else begin
                        v = rand64();
                    end
                    w = (sb >= 8) ? (v & wmask) : ((w << (8 * sb)) | (v & wmask));
                end
                line_words.push_back(w);
            end
        end
    endtask

    task automatic push_random_lines(input int count);
        int r;
        repeat (count) begin
            r = $urandom_range(0, 99);
            if (r < 5) push_line(0, 1'b0);
            else if (r < 13) push_line(1, 1'b0);
            else if (r < 85) push_line(2 + (r - 13) / 12, 1'b0);
            else if (r < 93) push_line(8, 1'b0);
            else push_line(9, 1'b0);
        end
    endtask

    task automatic wait_words_sent();
        while (line_words.size() != 0 || i_s_axis_tvalid) @(posedge i_clk);
    endtask

    // Sender: a new item is offered only when the previous one was taken or none is up.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (!i_s_axis_tvalid || in_taken) begin
            if (line_words.size() != 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata <= line_words.pop_front();
            end else begin
                i_s_axis_tvalid <= 1'b0;
                i_s_axis_tdata <= rand64();
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off when the stimulus asks for it.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else if (stall_req != stall_seen) begin
            stall_seen = stall_req;
            hold_left = LONG_HOLD;
            i_m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
        end
    end

    // Classifies accepted words and checks accepted results against the oldest expectation.
    always @(posedge i_clk) begin : monitor
        int          sb;
        int          sz;
        logic [63:0] seg;
        logic [63:0] lim;
        logic [63:0] diff;
        line_class_t want;
        if (!i_rst_n) begin
            in_taken = 1'b0;
        end else begin
            in_taken = i_s_axis_tvalid && o_s_axis_tready;

            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (expected_classes.size() == 0) begin
                    report_error($sformatf("result 0x%h with no line pending", o_m_axis_tdata));
                end else begin
                    want = expected_classes.pop_front();
                    if (o_m_axis_tdata[6:0] !== want.size) begin
                        report_error($sformatf("compressed_size got %0d expected %0d",
                                               o_m_axis_tdata[6:0], want.size));
                    end
                    if (o_m_axis_tdata[10:7] !== want.enc) begin
                        report_error($sformatf("encoding got %0d expected %s",
                                               o_m_axis_tdata[10:7], want.enc.name()));
                    end
                end
            end

            if (in_taken) begin
                if (word_count == 0) first_word = i_s_axis_tdata;
                else if (i_s_axis_tdata != first_word) repeat_failed = 1'b1;
                if (i_s_axis_tdata != '0) any_nonzero = 1'b1;

                // Each mode walks its segments from the most significant one down.
                for (int m = 0; m < 6; m++) begin
                    sb = MODE_BASE_BYTES[m];
                    lim = width_mask(MODE_DELTA_BYTES[m]);
                    for (int j = 0; j < 8 / sb; j++) begin
                        seg = (i_s_axis_tdata >> (64 - 8 * sb * (j + 1))) & width_mask(sb);
                        if (!mode_failed[m] && seg > lim) begin
                            if (!base_valid[m]) begin
                                base_valid[m] = 1'b1;
                                mode_base[m] = seg;
                            end
                            diff = (seg >= mode_base[m]) ? seg - mode_base[m] : mode_base[m] - seg;
                            if (diff > lim) mode_failed[m] = 1'b1;
                        end
                    end
                end

                word_count++;
                if (word_count >= WORDS) begin
                    if (!any_nonzero) begin
                        sz = 1;
                        want.enc = ENC_ZERO;
                    end else if (!repeat_failed) begin
                        sz = 8;
                        want.enc = ENC_REP;
                    end else begin
                        sz = LINE_BYTES;
                        want.enc = ENC_NONE;
                        for (int m = 5; m >= 0; m--) begin
                            if (!mode_failed[m]) begin
                                sz = MODE_BASE_BYTES[m]
                                     + (WORDS * 8 / MODE_BASE_BYTES[m]) * MODE_DELTA_BYTES[m];
                                want.enc = MODE_ENC[m];
                            end
                        end
                    end
                    want.size = (sz > SIZE_MAX) ? 7'(SIZE_MAX) : 7'(sz);
                    expected_classes.push_back(want);
                    clear_line();
                end
            end
        end
    end

    // Ends the run when neither side has moved an item for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready)
                    || (o_m_axis_tvalid && i_m_axis_tready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("** bdi_line_size_classifier: FAILED **");
        $finish;
    end

    initial begin
        clear_line();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed lines: zero, all ones, alternating extremes, a repeated word, each mode at
        // its limits, random words and a repeat broken by a single bit.
        push_line(0, 1'b0);
        repeat (WORDS) line_words.push_back('1);
        for (int i = 0; i < WORDS; i++) line_words.push_back(i[0] ? '0 : '1);
        push_line(1, 1'b0);
        for (int k = 2; k <= 7; k++) push_line(k, 1'b1);
        push_line(8, 1'b0);
        push_line(9, 1'b0);

        push_random_lines(LINES_PER_PHASE);
        // Long receiver hold-off while the sender keeps offering words.
        stall_req = stall_req + 1;
        wait_words_sent();

        snd_idle_pct = 45;
        rcv_idle_pct = 14;
        push_random_lines(LINES_PER_PHASE);
        wait_words_sent();

        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        push_random_lines(LINES_PER_PHASE);
        wait_words_sent();

        while (expected_classes.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (err_count == 0) begin
            $display("** bdi_line_size_classifier: PASSED **");
        end else begin
            $display("** bdi_line_size_classifier: FAILED **");
        end
        $finish;
    end

endmodule
